// ===== sv/avcc_pkg.sv =====
`timescale 1ns / 1ps

package avcc_pkg;

  typedef enum logic [3:0] {
    K_VERSION   = 4'd0,
    K_PROFILE   = 4'd1,
    K_COMPAT    = 4'd2,
    K_LEVEL     = 4'd3,
    K_LENSIZE   = 4'd4,
    K_SPSCOUNT  = 4'd5,
    K_SPSLEN_HI = 4'd6,
    K_SPSLEN_LO = 4'd7,
    K_SPSDATA   = 4'd8,
    K_PPSCOUNT  = 4'd9,
    K_PPSLEN_HI = 4'd10,
    K_PPSLEN_LO = 4'd11,
    K_PPSDATA   = 4'd12,
    K_TRAILING  = 4'd13
  } kind_t;

  localparam logic [7:0] LENSIZE_MASK  = 8'h03;
  localparam logic [7:0] SPSCOUNT_MASK = 8'h1F;

  typedef struct packed {
    kind_t       field_kind;
    logic [15:0] field_value;
    logic [7:0]  unit_number;
    logic [15:0] byte_offset;
    logic        record_done;
  } result_t;

endpackage

// ===== sv/avcc_step.sv =====
`timescale 1ns / 1ps

// Parse state and per-byte classification. State advances on each accepted
// transaction; the result for that byte is combinational from the same state.
module avcc_step
  import avcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       record_start,
  output result_t    res
);

  kind_t       phase_r, phase_nxt;
  logic [7:0]  units_left_r, units_left_nxt;
  logic [7:0]  unit_index_r, unit_index_nxt;
  logic [7:0]  length_high_r, length_high_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [15:0] offset_count_r, offset_count_nxt;

  kind_t       kind;
  logic        pps;
  logic [7:0]  ul_dec;
  logic [15:0] bl_dec;
  logic [15:0] len_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= K_VERSION;
      units_left_r   <= 8'd0;
      unit_index_r   <= 8'd0;
      length_high_r  <= 8'd0;
      bytes_left_r   <= 16'd0;
      offset_count_r <= 16'd0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      units_left_r   <= units_left_nxt;
      unit_index_r   <= unit_index_nxt;
      length_high_r  <= length_high_nxt;
      bytes_left_r   <= bytes_left_nxt;
      offset_count_r <= offset_count_nxt;
    end
  end

  always_comb begin
    kind             = record_start ? K_VERSION : phase_r;
    pps              = (kind >= K_PPSCOUNT);
    ul_dec           = units_left_r - 8'd1;
    bl_dec           = bytes_left_r - 16'd1;
    len_full         = {length_high_r, data_byte};

    phase_nxt        = kind;
    units_left_nxt   = units_left_r;
    unit_index_nxt   = unit_index_r;
    length_high_nxt  = length_high_r;
    bytes_left_nxt   = bytes_left_r;
    offset_count_nxt = offset_count_r;

    res.field_kind   = kind;
    res.field_value  = {8'd0, data_byte};
    res.unit_number  = 8'd0;
    res.byte_offset  = 16'd0;
    res.record_done  = 1'b0;

    unique case (kind)
      K_VERSION:  phase_nxt = K_PROFILE;
      K_PROFILE:  phase_nxt = K_COMPAT;
      K_COMPAT:   phase_nxt = K_LEVEL;
      K_LEVEL:    phase_nxt = K_LENSIZE;
      K_LENSIZE: begin
        res.field_value = {8'd0, data_byte & LENSIZE_MASK};
        phase_nxt       = K_SPSCOUNT;
      end
      K_SPSCOUNT, K_PPSCOUNT: begin
        if (!pps) begin
          res.field_value = {8'd0, data_byte & SPSCOUNT_MASK};
        end
        units_left_nxt = res.field_value[7:0];
        unit_index_nxt = 8'd0;
        if (res.field_value[7:0] == 8'd0) begin
          if (pps) begin
            phase_nxt       = K_TRAILING;
            res.record_done = 1'b1;
          end else begin
            phase_nxt = K_PPSCOUNT;
          end
        end else begin
          phase_nxt = pps ? K_PPSLEN_HI : K_SPSLEN_HI;
        end
      end
      K_SPSLEN_HI, K_PPSLEN_HI: begin
        res.unit_number = unit_index_r;
        length_high_nxt = data_byte;
        phase_nxt       = pps ? K_PPSLEN_LO : K_SPSLEN_LO;
      end
      K_SPSLEN_LO, K_PPSLEN_LO, K_SPSDATA, K_PPSDATA: begin
        res.unit_number = unit_index_r;
        if (kind == K_SPSLEN_LO || kind == K_PPSLEN_LO) begin
          res.field_value  = len_full;
          bytes_left_nxt   = len_full;
          offset_count_nxt = 16'd0;
          phase_nxt        = pps ? K_PPSDATA : K_SPSDATA;
        end else begin
          res.byte_offset  = offset_count_r;
          offset_count_nxt = offset_count_r + 16'd1;
          bytes_left_nxt   = bl_dec;
        end
        // unit closes on an empty length or its last payload byte
        if (bytes_left_nxt == 16'd0) begin
          unit_index_nxt = unit_index_r + 8'd1;
          units_left_nxt = ul_dec;
          if (ul_dec == 8'd0) begin
            if (pps) begin
              phase_nxt       = K_TRAILING;
              res.record_done = 1'b1;
            end else begin
              phase_nxt = K_PPSCOUNT;
            end
          end else begin
            phase_nxt = pps ? K_PPSLEN_HI : K_SPSLEN_HI;
          end
        end
      end
      default: phase_nxt = K_TRAILING;
    endcase
  end

  a_done_to_trailing: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res.record_done) |=> (phase_r == K_TRAILING))
    else $error("record completed but parse not in trailing phase");

  a_offset_only_data: assert property (@(posedge clk) disable iff (!rst_n)
    (res.byte_offset != 16'd0) |->
      (res.field_kind == K_SPSDATA || res.field_kind == K_PPSDATA))
    else $error("byte offset set outside unit payload");

  a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && record_start) |=> (phase_r == K_PROFILE))
    else $error("record start did not restart the parse");

endmodule

// ===== sv/avcc_skid.sv =====
`timescale 1ns / 1ps

// Output register with one skid entry; in_stall comes from a flop only.
module avcc_skid
  import avcc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  result_t in_res,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  logic    main_valid_r, main_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t main_r, skid_r;
  logic    accept;
  logic    main_free;

  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !skid_valid_r;
  assign main_free = !main_valid_r || !out_stall;
  assign out_valid = main_valid_r;
  assign out_res   = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (main_free) begin
      main_valid_nxt = skid_valid_r || accept;
      skid_valid_nxt = 1'b0;
    end else if (accept) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      main_r <= skid_valid_r ? skid_r : in_res;
    end else if (accept) begin
      skid_r <= in_res;
    end
  end

  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry held with empty output register");

  a_stalled_output_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_res)))
    else $error("stalled result changed");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && main_valid_r && out_stall) |=> skid_valid_r)
    else $error("transaction dropped while output stalled");

endmodule

// ===== sv/avc_decoder_config_record_parser.sv =====
`timescale 1ns / 1ps

// avcC record byte classifier.
// Input channel: one payload byte of the record per transaction (after the box
// header), with in_record_start high on the first byte to restart the parse.
// Result channel: one transaction per input byte giving the field kind, the
// decoded value (masked byte, or the full 16-bit unit length on the low length
// byte), SPS/PPS unit number, offset within the unit and a record-done flag.
// Each result is registered in the output register, or held in the skid entry first when the output stalls.
// Throughput: one byte per cycle while in_stall is low; the per-byte phase update is a single
// combinational step between the parse state and the output register.
// A one-entry skid behind the output register lets a byte be taken while a
// result waits; in_stall rises only once both entries are full, and drops as
// soon as the receiver takes a result.
// Reset (rst_n low, synchronous) empties the output stage and sets the parse to
// expect the version byte with all counters at zero.
module avc_decoder_config_record_parser
  import avcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_record_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_field_kind,
  output logic [15:0] out_field_value,
  output logic [7:0]  out_unit_number,
  output logic [15:0] out_byte_offset,
  output logic        out_record_done
);

  result_t step_res;
  result_t out_res;
  logic    accept;

  assign accept = in_valid && !in_stall;

  avcc_step u_step (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .data_byte    (in_data_byte),
    .record_start (in_record_start),
    .res          (step_res)
  );

  avcc_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_res    (step_res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_field_kind  = out_res.field_kind;
  assign out_field_value = out_res.field_value;
  assign out_unit_number = out_res.unit_number;
  assign out_byte_offset = out_res.byte_offset;
  assign out_record_done = out_res.record_done;

endmodule

// ===== sim/avc_decoder_config_record_parser_test.sv =====
`timescale 1ns / 1ps

module avc_decoder_config_record_parser_test;
  import avcc_pkg::*;

  // Tracks the avcC parse alongside the block and holds the fields it should report
  class field_scoreboard;
    kind_t       phase;
    logic [7:0]  units_left;
    logic [7:0]  unit_index;
    logic [7:0]  length_high;
    logic [15:0] bytes_left;
    logic [15:0] offset_count;
    result_t     expected_fields[$];
    int          failures;
    int          checked;

    function new();
      phase        = K_VERSION;
      units_left   = '0;
      unit_index   = '0;
      length_high  = '0;
      bytes_left   = '0;
      offset_count = '0;
      failures     = 0;
      checked      = 0;
    endfunction

    // returns 1 when the last PPS has just closed
    function bit close_unit(bit pps);
      unit_index = unit_index + 8'd1;
      units_left = units_left - 8'd1;
      if (units_left == 8'd0) begin
        if (pps) begin
          phase = K_TRAILING;
          return 1'b1;
        end
        phase = K_PPSCOUNT;
      end else begin
        phase = pps ? K_PPSLEN_HI : K_SPSLEN_HI;
      end
      return 1'b0;
    endfunction

    function void note_byte(logic [7:0] b, logic start);
      result_t want;
      kind_t   k;
      bit      pps;
      if (start) phase = K_VERSION;
      k   = phase;
      pps = (k >= K_PPSCOUNT);
      want.field_kind  = k;
      want.field_value = {8'h00, b};
      want.unit_number = '0;
      want.byte_offset = '0;
      want.record_done = 1'b0;
      case (k)
        K_VERSION, K_PROFILE, K_COMPAT, K_LEVEL: begin
          phase = kind_t'(k + 1);
        end
        K_LENSIZE: begin
          want.field_value = {8'h00, b & LENSIZE_MASK};
          phase = K_SPSCOUNT;
        end
        K_SPSCOUNT, K_PPSCOUNT: begin
          if (k == K_SPSCOUNT) want.field_value = {8'h00, b & SPSCOUNT_MASK};
          units_left = want.field_value[7:0];
          unit_index = '0;
          if (units_left == 8'd0) begin
            if (pps) begin
              phase = K_TRAILING;
              want.record_done = 1'b1;
            end else begin
              phase = K_PPSCOUNT;
            end
          end else begin
            phase = kind_t'(k + 1);
          end
        end
        K_SPSLEN_HI, K_PPSLEN_HI: begin
          want.unit_number = unit_index;
          length_high = b;
          phase = kind_t'(k + 1);
        end
        K_SPSLEN_LO, K_PPSLEN_LO: begin
          want.unit_number = unit_index;
          want.field_value = {length_high, b};
          bytes_left   = want.field_value;
          offset_count = '0;
          // zero-length unit closes on its low length byte
          if (want.field_value == 16'd0) want.record_done = close_unit(pps);
          else phase = kind_t'(k + 1);
        end
        K_SPSDATA, K_PPSDATA: begin
          want.unit_number = unit_index;
          want.byte_offset = offset_count;
          offset_count = offset_count + 16'd1;
          bytes_left   = bytes_left - 16'd1;
          if (bytes_left == 16'd0) want.record_done = close_unit(pps);
        end
        default: begin
          phase = K_TRAILING;
        end
      endcase
      expected_fields.push_back(want);
    endfunction

    function void check_field(result_t got);
      result_t want;
      checked++;
      if (expected_fields.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: result with nothing outstanding: kind %0d value %h", $realtime,
                   got.field_kind, got.field_value);
        return;
      end
      want = expected_fields.pop_front();
      if (got.field_kind !== want.field_kind || got.field_value !== want.field_value ||
          got.unit_number !== want.unit_number || got.byte_offset !== want.byte_offset ||
          got.record_done !== want.record_done) begin
        failures++;
        if (failures <= 10) begin
          $write("%0t: mismatch (expected/actual) kind %0d/%0d value %h/%h unit %0d/%0d ",
                 $realtime, want.field_kind, got.field_kind, want.field_value,
                 got.field_value, want.unit_number, got.unit_number);
          $display("offset %0d/%0d done %b/%b", want.byte_offset, got.byte_offset,
                   want.record_done, got.record_done);
        end
      end
    endfunction

    function int pending();
      return expected_fields.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_record_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_field_kind;
  logic [15:0] out_field_value;
  logic [7:0]  out_unit_number;
  logic [15:0] out_byte_offset;
  logic        out_record_done;

  field_scoreboard sb = new();
  bit              quiet = 1'b0;
  int              bytes_sent = 0;
  logic [8:0]      record_bytes[$];   // {record_start, byte}
  int unsigned     byte_cap;

  avc_decoder_config_record_parser u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_record_start (in_record_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_field_kind  (out_field_kind),
    .out_field_value (out_field_value),
    .out_unit_number (out_unit_number),
    .out_byte_offset (out_byte_offset),
    .out_record_done (out_record_done)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic start);
    while (!quiet && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= b;
    in_record_start <= start;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b, start);
    bytes_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic void put(input logic start, input logic [7:0] b);
    if (record_bytes.size() < byte_cap) record_bytes.push_back({start, b});
  endfunction

  function automatic void put_unit(input bit broken);
    int unsigned len;
    if (broken) len = $urandom_range(0, 65535);
    else if ($urandom_range(0, 39) == 0) len = $urandom_range(256, 400);
    else len = $urandom_range(0, 6);
    put(1'b0, len[15:8]);
    put(1'b0, len[7:0]);
    for (int unsigned i = 0; i < len && record_bytes.size() < byte_cap; i++)
      put(1'b0, 8'($urandom));
  endfunction

  // a broken record is cut short; the next record's first byte restarts the parse
  function automatic void build_record(input bit broken);
    logic [7:0] cnt;
    record_bytes.delete();
    byte_cap = broken ? $urandom_range(1, 60) : 32'hFFFF_FFFF;
    put(1'b1, 8'($urandom));
    repeat (4) put(1'b0, 8'($urandom));
    if (broken) cnt = 8'($urandom);
    else cnt = {3'($urandom), 5'(($urandom_range(0, 19) == 0) ? $urandom_range(4, 31)
                                                            : $urandom_range(0, 3))};
    put(1'b0, cnt);
    for (int i = 0; i < int'(cnt[4:0]) && record_bytes.size() < byte_cap; i++)
      put_unit(broken);
    if (broken) cnt = 8'($urandom);
    else cnt = 8'(($urandom_range(0, 19) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3));
    put(1'b0, cnt);
    for (int i = 0; i < int'(cnt) && record_bytes.size() < byte_cap; i++)
      put_unit(broken);
    if (!broken) repeat ($urandom_range(0, 3)) put(1'b0, 8'($urandom));
  endfunction

  // result side: random stalls, one long hold-off, checking
  initial begin : result_side
    result_t got;
    int      hold_left;
    bit      held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.field_kind  = kind_t'(out_field_kind);
        got.field_value = out_field_value;
        got.unit_number = out_unit_number;
        got.byte_offset = out_byte_offset;
        got.record_done = out_record_done;
        sb.check_field(got);
      end
      if (hold_left == 0 && !held && sb.checked >= 200) begin
        hold_left = 120;
        held      = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 14);
      end
    end
  end

  initial begin : byte_side
    logic [8:0] directed[$];
    int         pick;
    bit         paused;
    paused = 1'b0;
    // full record: extremes, reserved bits set, two-byte SPS, zero-length PPS, trailing
    directed = '{9'h101, 9'h0FF, 9'h000, 9'h0FF, 9'h0FF, 9'h0E1, 9'h000, 9'h002,
                 9'h000, 9'h0FF, 9'h001, 9'h000, 9'h000, 9'h0AA,
                 // restart mid-record
                 9'h101, 9'h042,
                 9'h101, 9'h064, 9'h040, 9'h01F, 9'h0FC, 9'h0E0, 9'h000, 9'h055, 9'h0C3};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);
    drain();

    while (bytes_sent < 625) begin
      quiet = (bytes_sent >= 300 && bytes_sent < 420);
      if (!paused && bytes_sent >= 450) begin
        drain();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        build_record(1'b0);
      end else if (pick < 88) begin
        build_record(1'b1);
      end else begin
        record_bytes.delete();
        repeat ($urandom_range(1, 4))
          record_bytes.push_back({1'($urandom_range(0, 3) == 0), 8'($urandom)});
      end
      foreach (record_bytes[i]) send_byte(record_bytes[i][7:0], record_bytes[i][8]);
    end
    quiet = 1'b0;
    drain();
    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/avcc_pkg.sv
sv/avcc_step.sv
sv/avcc_skid.sv
sv/avc_decoder_config_record_parser.sv
sim/avc_decoder_config_record_parser_test.sv
